>>> hw/rtl/aldm_pkg.sv
package aldm_pkg;

  // Store geometry
  localparam int unsigned MaxLen   = 262144;
  localparam int unsigned AddrW    = $clog2(MaxLen);
  localparam int unsigned LenW     = $clog2(MaxLen) + 1;
  localparam int unsigned ResetLen = (10 * 1024 < MaxLen) ? 10 * 1024 : MaxLen;

  // Sample formats
  localparam int unsigned SampleW  = 12;
  localparam int unsigned DropBits = 4;
  localparam int unsigned LevelW   = 8;
  localparam logic [LevelW-1:0] MidLevel = LevelW'(128);

  // Access plan for one transaction, from the position unit to the datapath
  typedef struct packed {
    logic [AddrW-1:0] wr_addr;
    logic [AddrW-1:0] rd_addr;
    logic             rd_fwd;    // read hits the entry written in the same cycle
    logic             rd_blank;  // read entry never written since reset
  } aldm_access_t;

endpackage

>>> hw/rtl/aldm_if.sv
interface aldm_in_if import aldm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface aldm_out_if import aldm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] mixed_level;

  modport source (output valid, output mixed_level, input ready);
  modport sink   (input valid, input mixed_level, output ready);
endinterface

>>> hw/rtl/aldm_store_ram.sv
module aldm_store_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; output holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/aldm_position.sv
module aldm_position import aldm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  output aldm_access_t    access_o
);

  logic [AddrW-1:0] pos_q, pos_d;
  logic [LenW-1:0]  active_q, active_d;
  logic [LenW-1:0]  pending_q, pending_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]  pos_plus;
  logic             wrap;
  logic [AddrW-1:0] next_pos;
  logic [LenW-1:0]  fill_after;

  // Advance the position and wrap at the active length
  assign pos_plus   = LenW'(pos_q) + LenW'(1);
  assign wrap       = (pos_plus >= active_q);
  assign next_pos   = wrap ? '0 : pos_plus[AddrW-1:0];

  // Written entries always form a prefix of the store; grow it on a write at its end
  assign fill_after = (LenW'(pos_q) == fill_q) ? fill_q + LenW'(1) : fill_q;

  always_comb begin
    access_o.wr_addr  = pos_q;
    access_o.rd_addr  = next_pos;
    access_o.rd_fwd   = (next_pos == pos_q);
    access_o.rd_blank = (LenW'(next_pos) >= fill_after);
  end

  // Clamp the requested length to 1..MaxLen
  always_comb begin
    pending_d = pending_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        pending_d = LenW'(1);
      end else if (cfg_wdata_i > LenW'(MaxLen)) begin
        pending_d = LenW'(MaxLen);
      end else begin
        pending_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    fill_d   = fill_q;
    if (advance_i) begin
      pos_d  = next_pos;
      fill_d = fill_after;
      if (wrap) begin
        active_d = pending_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= LenW'(ResetLen);
      pending_q <= LenW'(ResetLen);
      fill_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      pending_q <= pending_d;
      fill_q    <= fill_d;
    end
  end

endmodule

>>> hw/rtl/audio_loop_delay_mixer_top.sv
// Loop delay mixer: each sample transaction drops the low four bits of the 12-bit converter
// sample, stores the result in a circular store of MaxLen entries and mixes half of the
// oldest stored sample with half of the current one into an 8-bit level (0..254). One
// sample is taken every clock cycle while the output is not back-pressured; its level
// passes through the registered read of the dual-port sample store and then the output
// register. Output back-pressure stalls the input only once both of those stages are full.
// A new loop length from cfg_wdata_i (0 reads as 1, values above MaxLen as MaxLen) takes
// effect at the next wrap of the write position. The store needs no clearing pass after
// reset: a fill count marks the written prefix and unwritten entries read as silence.
module audio_loop_delay_mixer_top import aldm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  aldm_in_if.sink         sample_i,
  aldm_out_if.source      level_o
);

  aldm_access_t      access;
  logic              accept;
  logic [LevelW-1:0] cur_ofs;
  logic [LevelW-1:0] rdata;
  logic [LevelW-1:0] old_ofs;
  logic [LevelW-1:0] mix;
  logic              s1_move;

  logic              s1_valid_q, s1_valid_d;
  logic [LevelW-1:0] s1_cur_q;
  logic [LevelW-1:0] s1_alt_q;
  logic              s1_use_alt_q;
  logic              out_valid_q, out_valid_d;
  logic [LevelW-1:0] out_level_q;

  assign cur_ofs = sample_i.adc_sample[SampleW-1:DropBits];

  // Stage one moves on when the output register is free or being emptied
  assign s1_move        = s1_valid_q && (!out_valid_q || level_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_move;
  assign accept         = sample_i.valid && sample_i.ready;

  aldm_position u_position (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (accept),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .access_o   (access)
  );

  aldm_store_ram #(
    .DataW(LevelW),
    .Depth(MaxLen)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(access.wr_addr),
    .wdata_i(cur_ofs),
    .re_i   (accept),
    .raddr_i(access.rd_addr),
    .rdata_o(rdata)
  );

  // Hold the current sample and any bypass of the store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q     <= cur_ofs;
      s1_alt_q     <= access.rd_fwd ? cur_ofs : MidLevel;
      s1_use_alt_q <= access.rd_fwd || access.rd_blank;
    end
  end

  // Mix half of each sample; offset form already carries the +128
  assign old_ofs = s1_use_alt_q ? s1_alt_q : rdata;
  assign mix     = (old_ofs >> 1) + (s1_cur_q >> 1);

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_level_q <= mix;
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (level_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
      s1_valid_d  = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign level_o.valid       = out_valid_q;
  assign level_o.mixed_level = out_level_q;

endmodule

>>> hw/rtl/aldm_checker.sv
module aldm_checker import aldm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [LevelW-1:0] out_level_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i))
    else $error("stalled result changed");

  // Mixed level never reaches full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_level_i != {LevelW{1'b1}})
    else $error("mixed level out of range");

  // Every accepted sample yields a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("result missing after accepted sample");

endmodule

bind audio_loop_delay_mixer_top aldm_checker u_aldm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_i.valid),
  .in_ready_i (sample_i.ready),
  .out_valid_i(level_o.valid),
  .out_ready_i(level_o.ready),
  .out_level_i(level_o.mixed_level)
);

>>> tb/sv/tb_top.sv
module tb_top import aldm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  localparam int DrainCycles = 4;
  localparam int MaxReports = 40;
  localparam int NoPin = -1;

  typedef enum logic {PACE_STREAM, PACE_RANDOM} pace_e;
  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CONFIG, ROW_FILL} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [19:0] value;
    int          pin;
  } stim_row_t;

  localparam int NumRows = 20;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [LenW-1:0] cfg_wdata;

  aldm_in_if  sample_if ();
  aldm_out_if level_if ();

  audio_loop_delay_mixer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_if),
    .level_o     (level_if)
  );

  // Echo predictor state: signed samples, position, live and requested loop length
  bit   [7:0]       echo_store [MaxLen];
  logic [AddrW-1:0] loop_pos;
  logic [LenW-1:0]  loop_len;
  logic [LenW-1:0]  next_len;

  logic [LevelW-1:0] level_q [$];
  logic [LevelW-1:0] mixed_guess;
  int                pinned_level;
  int                mismatch_count;
  int                cycle_count;
  pace_e             sender_pace;
  pace_e             receiver_pace;
  bit                hold_off_req;

  // Start-of-run directed plan: extremes into silence, length one, short loop
  stim_row_t directed_plan [NumRows] = '{
    '{ROW_SAMPLE, 20'h000, 64},
    '{ROW_SAMPLE, 20'hFFF, 191},
    '{ROW_SAMPLE, 20'h800, 128},
    '{ROW_SAMPLE, 20'h7FF, 127},
    '{ROW_SAMPLE, 20'h00F, 64},
    '{ROW_SAMPLE, 20'h810, 128},
    '{ROW_SAMPLE, 20'h555, 106},
    '{ROW_SAMPLE, 20'hAAA, 149},
    // zero length reads as one, taken at the first wrap of the reset loop
    '{ROW_CONFIG, 20'h00000, NoPin},
    '{ROW_FILL,   20'h00000, NoPin},
    // loop of one: the sample just written comes straight back
    '{ROW_SAMPLE, 20'h000, 0},
    '{ROW_SAMPLE, 20'hFFF, 254},
    '{ROW_SAMPLE, 20'h7F0, 126},
    '{ROW_SAMPLE, 20'h800, 128},
    '{ROW_CONFIG, 20'h00003, NoPin},
    '{ROW_SAMPLE, 20'h123, NoPin},
    '{ROW_SAMPLE, 20'hF0F, NoPin},
    '{ROW_SAMPLE, 20'h0F0, NoPin},
    '{ROW_SAMPLE, 20'h9AB, NoPin},
    '{ROW_SAMPLE, 20'h456, NoPin}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
    if (v == '0) return LenW'(1);
    if (v > LenW'(MaxLen)) return LenW'(MaxLen);
    return v;
  endfunction

  // Store the current sample, advance the position, mix with the oldest entry
  function automatic logic [LevelW-1:0] mix_sample(input logic [SampleW-1:0] adc);
    logic [7:0]      cur_ofs;
    logic [7:0]      old_ofs;
    logic [LenW-1:0] nxt;
    cur_ofs = adc[SampleW-1:DropBits];
    echo_store[loop_pos] = cur_ofs ^ 8'h80;
    nxt = LenW'(loop_pos) + 1'b1;
    if (nxt >= loop_len) begin
      nxt = '0;
      loop_len = next_len;
    end
    loop_pos = nxt[AddrW-1:0];
    old_ofs = echo_store[loop_pos] ^ 8'h80;
    return LevelW'({1'b0, old_ofs[7:1]} + {1'b0, cur_ofs[7:1]});
  endfunction

  function automatic int draw_wait(input pace_e pace);
    if (pace == PACE_STREAM) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [SampleW-1:0] draw_sample();
    logic [SampleW-1:0] s;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: s = 12'h000;
        1: s = 12'hFFF;
        2: s = 12'h800;
        default: s = 12'h7FF;
      endcase
    end else begin
      s = SampleW'($urandom_range(0, 4095));
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MaxReports)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one sample after a gap drawn for the sender pace and hold it until the transaction
  task automatic send_sample(input logic [SampleW-1:0] s, input int pin);
    int gap;
    gap = draw_wait(sender_pace);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.adc_sample <= s;
    pinned_level         <= pin;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  // Drop valid and wait until every expected level has come out
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (level_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [LenW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    next_len = clamp_len(v);
    @(posedge clk_i);
  endtask

  // Back-to-back samples, for running a long loop round to its wrap
  task automatic run_stream(input int n);
    pace_e saved;
    saved = sender_pace;
    sender_pace = PACE_STREAM;
    receiver_pace = PACE_STREAM;
    repeat (n) send_sample(draw_sample(), NoPin);
    sender_pace = saved;
    receiver_pace = saved;
  endtask

  // Predict a level for every input transaction
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      mixed_guess = mix_sample(sample_if.adc_sample);
      if (pinned_level >= 0) level_q.push_back(LevelW'(pinned_level));
      else level_q.push_back(mixed_guess);
    end
  end

  // Check every output transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && level_if.valid && level_if.ready) begin
      if (level_q.size() == 0) begin
        report_mismatch("unexpected level", int'(level_if.mixed_level), -1);
      end else begin
        if (level_if.mixed_level !== level_q[0])
          report_mismatch("mixed_level", int'(level_if.mixed_level), int'(level_q[0]));
        void'(level_q.pop_front());
      end
    end
  end

  // Sink side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    level_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(receiver_pace);
      if (hold_off_req) begin
        stall = 64;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        level_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      level_if.ready <= 1'b1;
      do @(posedge clk_i); while (!level_if.valid);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [LenW-1:0] len;
    cycle_count          = 0;
    mismatch_count       = 0;
    hold_off_req         = 1'b0;
    sender_pace          = PACE_RANDOM;
    receiver_pace        = PACE_RANDOM;
    loop_pos             = '0;
    loop_len             = LenW'(ResetLen);
    next_len             = LenW'(ResetLen);
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    sample_if.valid      <= 1'b0;
    sample_if.adc_sample <= '0;
    pinned_level         <= NoPin;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    for (int r = 0; r < NumRows; r++) begin
      case (directed_plan[r].op)
        ROW_SAMPLE: send_sample(directed_plan[r].value[SampleW-1:0], directed_plan[r].pin);
        ROW_CONFIG: begin
          wait_idle();
          write_len(directed_plan[r].value[LenW-1:0]);
        end
        default: begin
          wait_idle();
          run_stream(int'(loop_len) - int'(loop_pos));
        end
      endcase
    end

    // Random phases over a spread of short loop lengths
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: len = LenW'(2);
        1: len = LenW'($urandom_range(3, 16));
        2: begin
          // overwrite a request before it is ever taken
          write_len(LenW'(100));
          len = LenW'($urandom_range(1, 8));
        end
        3: len = LenW'($urandom_range(17, 120));
        4: len = LenW'(1);
        default: len = LenW'($urandom_range(1, 40));
      endcase
      write_len(len);
      sender_pace   = (ph == 3 || ph == 4) ? PACE_STREAM : PACE_RANDOM;
      receiver_pace = (ph == 3) ? PACE_STREAM : PACE_RANDOM;
      // fill the pipeline against a stalled output
      if (ph == 4) hold_off_req = 1'b1;
      repeat (75) send_sample(draw_sample(), NoPin);
    end

    // Lengths beyond the store clamp to the full store, taken at the next wrap
    wait_idle();
    write_len('1);
    write_len(LenW'(MaxLen + 1));
    write_len(LenW'(MaxLen));
    sender_pace   = PACE_RANDOM;
    receiver_pace = PACE_RANDOM;
    repeat (40) send_sample(draw_sample(), NoPin);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/aldm_pkg.sv
hw/rtl/aldm_if.sv
hw/rtl/aldm_store_ram.sv
hw/rtl/aldm_position.sv
hw/rtl/audio_loop_delay_mixer_top.sv
hw/rtl/aldm_checker.sv
tb/sv/tb_top.sv
